FILE: hw/rtl/hnf_pkg.sv
// Shared types, constants and the nibble-to-ASCII helper of the hex number formatter.
`timescale 1ns / 1ps

package hnf_pkg;

  localparam int NUMBER_BITS_DEF = 64;
  localparam int MAX_WIDTH_DEF   = 48;

  localparam int IN_NUM_W  = 64;
  localparam int WIDTH_W   = 6;
  localparam int CHAR_W    = 8;
  localparam int NIBBLE_W  = 4;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;
  localparam logic [CHAR_W-1:0] UPPER_A    = 8'h41;
  localparam logic [CHAR_W-1:0] LOWER_A    = 8'h61;

  typedef enum logic [1:0] {
    EMIT_NONE  = 2'd0,
    EMIT_PAD   = 2'd1,
    EMIT_DIGIT = 2'd2,
    EMIT_SPACE = 2'd3
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    emit_sel_t emit_sel;
  } hnf_cmd_t;

  typedef struct packed {
    logic out_free;
    logic left;
    logic pad_zero;
    logic pad_one;
    logic dig_zero;
    logic rem_one;
  } hnf_status_t;

  function automatic logic [CHAR_W-1:0] hex_ascii(input logic [NIBBLE_W-1:0] nib,
                                                  input logic upper);
    logic [CHAR_W-1:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      return ZERO_CHAR + wide;
    end
    return (upper ? UPPER_A : LOWER_A) + wide - 8'd10;
  endfunction

endpackage

FILE: hw/rtl/hnf_ctrl.sv
// Controller state machine that sequences pad, digit and space characters.
`timescale 1ns / 1ps

module hnf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hnf_pkg::hnf_status_t status,
  output hnf_pkg::hnf_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PLAN = 5'b00010,
    S_PRE  = 5'b00100,
    S_DIG  = 5'b01000,
    S_POST = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.emit_sel = hnf_pkg::EMIT_NONE;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        if (!status.left && !status.pad_zero) begin
          state_nxt = S_PRE;
        end else begin
          state_nxt = S_DIG;
        end
      end
      S_PRE: begin
        if (status.out_free) begin
          cmd.emit_sel = hnf_pkg::EMIT_PAD;
          if (status.pad_one) begin
            state_nxt = S_DIG;
          end
        end
      end
      S_DIG: begin
        if (status.out_free) begin
          cmd.emit_sel = hnf_pkg::EMIT_DIGIT;
          if (status.dig_zero) begin
            state_nxt = (status.left && !status.pad_zero) ? S_POST : S_IDLE;
          end
        end
      end
      S_POST: begin
        if (status.out_free) begin
          cmd.emit_sel = hnf_pkg::EMIT_SPACE;
          if (status.pad_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/hnf_datapath.sv
// Datapath: item registers, digit and pad counters, character mux and output register.
`timescale 1ns / 1ps

module hnf_datapath #(
  parameter int NUMBER_BITS = hnf_pkg::NUMBER_BITS_DEF,
  parameter int MAX_WIDTH   = hnf_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hnf_pkg::hnf_cmd_t             cmd,
  output hnf_pkg::hnf_status_t          status,
  input  logic [hnf_pkg::IN_NUM_W-1:0]  in_number_value,
  input  logic [hnf_pkg::WIDTH_W-1:0]   in_field_width,
  input  logic [hnf_pkg::CHAR_W-1:0]    in_pad_character,
  input  logic                          in_left_justify,
  input  logic                          cfg_write_enable,
  input  logic                          cfg_upper_case_letters,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hnf_pkg::CHAR_W-1:0]    out_character,
  output logic                          out_last_character,
  output logic [hnf_pkg::WIDTH_W-1:0]   out_chars_emitted
);

  localparam int NIBBLES = (NUMBER_BITS + hnf_pkg::NIBBLE_W - 1) / hnf_pkg::NIBBLE_W;
  localparam int NUM_W   = NIBBLES * hnf_pkg::NIBBLE_W;
  localparam int IDX_W   = $clog2(NIBBLES);
  localparam int WW      = hnf_pkg::WIDTH_W;

  logic [NUM_W-1:0]              num_r, num_nxt;
  logic [IDX_W-1:0]              dig_r, dig_nxt;
  logic [WW-1:0]                 pad_r, pad_nxt;
  logic [WW-1:0]                 rem_r, rem_nxt;
  logic [WW-1:0]                 cnt_r, cnt_nxt;
  logic [hnf_pkg::CHAR_W-1:0]    padch_r, padch_nxt;
  logic                          left_r, left_nxt;
  logic                          upper_r, upper_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [hnf_pkg::CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [WW-1:0]                 out_cnt_r, out_cnt_nxt;

  logic [NUM_W-1:0]              num_in;
  logic [IDX_W-1:0]              top_idx;
  logic [WW-1:0]                 digits;
  logic [WW-1:0]                 wsat;
  logic                          emit;
  logic [hnf_pkg::NIBBLE_W-1:0]  nib;
  logic [hnf_pkg::CHAR_W-1:0]    char_sel;

  // Field sizing of a new item: highest significant nibble, saturated width.
  always_comb begin
    num_in  = NUM_W'(in_number_value[NUMBER_BITS-1:0]);
    top_idx = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      if (num_in[i*hnf_pkg::NIBBLE_W +: hnf_pkg::NIBBLE_W] != '0) begin
        top_idx = IDX_W'(i);
      end
    end
    digits = WW'(top_idx) + WW'(1);
    wsat   = (in_field_width > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : in_field_width;
  end

  assign emit = (cmd.emit_sel != hnf_pkg::EMIT_NONE);
  assign nib  = num_r[dig_r*hnf_pkg::NIBBLE_W +: hnf_pkg::NIBBLE_W];

  always_comb begin
    unique case (cmd.emit_sel)
      hnf_pkg::EMIT_PAD:   char_sel = padch_r;
      hnf_pkg::EMIT_DIGIT: char_sel = hnf_pkg::hex_ascii(nib, upper_r);
      hnf_pkg::EMIT_SPACE: char_sel = hnf_pkg::SPACE_CHAR;
      default:             char_sel = '0;
    endcase
  end

  always_comb begin
    num_nxt       = num_r;
    dig_nxt       = dig_r;
    pad_nxt       = pad_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    padch_nxt     = padch_r;
    left_nxt      = left_r;
    upper_nxt     = cfg_write_enable ? cfg_upper_case_letters : upper_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_cnt_nxt   = out_cnt_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    if (cmd.load) begin
      num_nxt   = num_in;
      dig_nxt   = top_idx;
      pad_nxt   = (wsat > digits) ? (wsat - digits) : '0;
      rem_nxt   = (wsat > digits) ? wsat : digits;
      cnt_nxt   = '0;
      padch_nxt = in_pad_character;
      left_nxt  = in_left_justify;
    end
    if (emit) begin
      cnt_nxt       = cnt_r + WW'(1);
      rem_nxt       = rem_r - WW'(1);
      out_valid_nxt = 1'b1;
      out_char_nxt  = char_sel;
      out_last_nxt  = (rem_r == WW'(1));
      out_cnt_nxt   = cnt_r + WW'(1);
      if (cmd.emit_sel == hnf_pkg::EMIT_DIGIT) begin
        if (dig_r != '0) begin
          dig_nxt = dig_r - IDX_W'(1);
        end
      end else begin
        pad_nxt = pad_r - WW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      upper_r     <= 1'b1;
    end else begin
      out_valid_r <= out_valid_nxt;
      upper_r     <= upper_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    dig_r      <= dig_nxt;
    pad_r      <= pad_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    padch_r    <= padch_nxt;
    left_r     <= left_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign status.left     = left_r;
  assign status.pad_zero = (pad_r == '0);
  assign status.pad_one  = (pad_r == WW'(1));
  assign status.dig_zero = (dig_r == '0);
  assign status.rem_one  = (rem_r == WW'(1));

  assign out_valid          = out_valid_r;
  assign out_character      = out_char_r;
  assign out_last_character = out_last_r;
  assign out_chars_emitted  = out_cnt_r;

endmodule

FILE: hw/rtl/hex_number_formatter.sv
// Top level of the hex number formatter: controller, datapath and assertions.
`timescale 1ns / 1ps

// The formatter takes one item (a number, a field width, a pad character and a
// left-justify flag) and sends out its printf-style hexadecimal text, one
// character per output item, most significant digit first, with the last one
// flagged and a running character count on every one. An item is taken and
// its field sized in the idle state, a planning state picks the pad or digit
// path, and then the character sequencer puts one character per cycle into
// the output register while that register has room, so a stalling sink holds
// it back. An item gives max(digits, saturated width) characters. The
// one-character output register sets the pace; a new item is accepted as
// soon as the last character of the previous one has entered the output
// register, even while that character still waits for the sink. Widths above
// MAX_WIDTH saturate, only the low NUMBER_BITS bits of the number are printed,
// and the letter case of digits ten to fifteen comes from the configuration
// register, which resets to upper case and is written with cfg_write_enable;
// the user must write it only while idle, as the block does not enforce it.
module hex_number_formatter #(
  parameter int NUMBER_BITS = hnf_pkg::NUMBER_BITS_DEF,
  parameter int MAX_WIDTH   = hnf_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hnf_pkg::IN_NUM_W-1:0]  in_number_value,
  input  logic [hnf_pkg::WIDTH_W-1:0]   in_field_width,
  input  logic [hnf_pkg::CHAR_W-1:0]    in_pad_character,
  input  logic                          in_left_justify,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hnf_pkg::CHAR_W-1:0]    out_character,
  output logic                          out_last_character,
  output logic [hnf_pkg::WIDTH_W-1:0]   out_chars_emitted,
  input  logic                          cfg_write_enable,
  input  logic                          cfg_upper_case_letters
);

  hnf_pkg::hnf_cmd_t    cmd;
  hnf_pkg::hnf_status_t status;

  // The controller decides which kind of character goes out each cycle.
  hnf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the item, the counters and the output register.
  hnf_datapath #(
    .NUMBER_BITS (NUMBER_BITS),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_datapath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .status                 (status),
    .in_number_value        (in_number_value),
    .in_field_width         (in_field_width),
    .in_pad_character       (in_pad_character),
    .in_left_justify        (in_left_justify),
    .cfg_write_enable       (cfg_write_enable),
    .cfg_upper_case_letters (cfg_upper_case_letters),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_character          (out_character),
    .out_last_character     (out_last_character),
    .out_chars_emitted      (out_chars_emitted)
  );

`ifndef NO_ASSERTIONS
  // While the block is ready for a new item, no character is being produced.
  a_idle_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (cmd.emit_sel == hnf_pkg::EMIT_NONE))
    else $error("character produced while accepting an item");

  // The final character of a field returns the controller to idle.
  a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.emit_sel != hnf_pkg::EMIT_NONE) && status.rem_one) |=> in_ready)
    else $error("controller still busy after the last character");

  // A character is produced only when the output register can take it.
  a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sel != hnf_pkg::EMIT_NONE) |-> status.out_free)
    else $error("character produced into a full output register");

  // Every character on the output carries a nonzero running count.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_chars_emitted != '0))
    else $error("output character with zero count");
`endif

endmodule
